@@ rtl/dct2d_forward_quantizer_assert.svh @@
// assertion macros used by the checker file
`ifndef DCT2D_FORWARD_QUANTIZER_ASSERT_SVH
`define DCT2D_FORWARD_QUANTIZER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define DFQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define DFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dfq_pkg.sv @@
// shared types, constants and cosine table functions of the dct quantizer
package dfq_pkg;

    localparam int BLOCK_N_DEF        = 8;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int SAMPLE_W           = 8;
    localparam int LEVEL_W            = 12;
    localparam int QSHIFT_W           = 4;
    localparam int LEVEL_MAX          = 2047;
    localparam int LEVEL_MIN          = -2048;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // one loaded block waiting for the transform
    typedef struct packed {
        logic                bank;
        logic [QSHIFT_W-1:0] qshift;
    } t_job;

    // restoring divide, used only while elaborating the table
    function automatic longint unsigned udiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // integer square root
    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        v   = v_in;
        res = 64'd0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // cos(pi*m/(2n)) in q30 by a taylor series
    function automatic longint unsigned cos_q30(input int m, input int n);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        bit              neg;
        x    = udiv(PI_Q30 * longint'(m), longint'(2 * n));
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        neg  = 1'b1;
        for (int k = 1; k <= 12; k++) begin
            term = udiv((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
            if (neg) sum = sum - longint'(term);
            else sum = sum + longint'(term);
            neg = !neg;
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        return longint'(sum);
    endfunction

    // orthonormal dct-ii basis entry (i, j), scaled by 2^f, rounded
    function automatic int cos_coef(input int n, input int f, input int i, input int j);
        longint unsigned s0;
        longint unsigned s1;
        longint unsigned mag;
        longint unsigned mm;
        int              m;
        int              shift;
        bit              neg;
        s0    = isqrt64(udiv(64'd1 << 60, longint'(n)));
        s1    = isqrt64(udiv(64'd1 << 61, longint'(n)));
        shift = 60 - f;
        mm    = longint'((2 * j + 1) * i);
        mm    = mm - udiv(mm, longint'(4 * n)) * longint'(4 * n);
        m     = int'(mm);
        neg   = 1'b0;
        if (m > 2 * n) m = 4 * n - m;
        if (m > n) begin
            m   = 2 * n - m;
            neg = 1'b1;
        end
        if (i == 0) mag = s0 * ONE_Q30;
        else mag = s1 * cos_q30(m, n);
        mag = (mag + (64'd1 << (shift - 1))) >> shift;
        return neg ? -int'(mag) : int'(mag);
    endfunction

endpackage

@@ rtl/dct2d_forward_quantizer.sv @@
// Forward 8x8 (BLOCK_N x BLOCK_N) orthonormal DCT-II with power-of-two
// quantization. Samples stream in raster order at one per cycle, while
// o_in_stall is low, into one of two sample banks; a finished block is
// queued and the other bank keeps loading. One shared multiply-accumulate
// unit then does the row pass, drains, and does the column pass with one
// column coefficient in flight through read, multiply, accumulate and
// quantize at a time. The row pass of a block starts only once the last
// level of the previous block has been loaded into the output register.
// Levels leave in raster order with o_last on the final one; qshift is
// sampled when the last sample of a block is accepted.
module dct2d_forward_quantizer #(
    parameter int BLOCK_N        = dfq_pkg::BLOCK_N_DEF,
    parameter int COEF_FRAC_BITS = dfq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dfq_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [dfq_pkg::LEVEL_W-1:0] o_level,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [dfq_pkg::QSHIFT_W-1:0]       i_cfg_wdata
);
    import dfq_pkg::*;

    localparam int AW = $clog2(BLOCK_N * BLOCK_N);

    logic                smp_we;
    logic                smp_bank;
    logic [AW-1:0]       smp_addr;
    logic [SAMPLE_W-1:0] smp_data;
    logic                push;
    logic                pop;
    logic                q_valid;
    logic                q_full;
    t_job                job_in;
    t_job                job_out;

    // sample loader
    dfq_front #(.BLOCK_N(BLOCK_N)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_queue_full (q_full),
        .i_sample     (i_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_in_stall   (o_in_stall),
        .o_smp_we     (smp_we),
        .o_smp_bank   (smp_bank),
        .o_smp_addr   (smp_addr),
        .o_smp_data   (smp_data),
        .o_push       (push),
        .o_job        (job_in)
    );

    // loaded blocks waiting for the transform
    dfq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (job_out)
    );

    // transform and quantizer
    dfq_back #(
        .BLOCK_N        (BLOCK_N),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp_we    (smp_we),
        .i_smp_bank  (smp_bank),
        .i_smp_addr  (smp_addr),
        .i_smp_data  (smp_data),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .i_out_stall (i_out_stall),
        .o_job_pop   (pop),
        .o_out_valid (o_out_valid),
        .o_level     (o_level),
        .o_last      (o_last)
    );

endmodule

@@ rtl/dfq_front.sv @@
// front end: loads samples into the bank memory and queues finished blocks
module dfq_front #(
    parameter int BLOCK_N = dfq_pkg::BLOCK_N_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_queue_full,
    input  logic [dfq_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_cfg_we,
    input  logic [dfq_pkg::QSHIFT_W-1:0]  i_cfg_wdata,
    output logic                          o_in_stall,
    output logic                          o_smp_we,
    output logic                          o_smp_bank,
    output logic [$clog2(BLOCK_N*BLOCK_N)-1:0] o_smp_addr,
    output logic [dfq_pkg::SAMPLE_W-1:0]  o_smp_data,
    output logic                          o_push,
    output dfq_pkg::t_job                 o_job
);
    import dfq_pkg::*;

    localparam int NN = BLOCK_N * BLOCK_N;
    localparam int AW = $clog2(NN);

    logic [AW-1:0]       r_pos, n_pos;
    logic                r_bank, n_bank;
    logic [QSHIFT_W-1:0] r_qshift;
    logic                accept;
    logic                blk_end;

    // request accepted only while a bank is free
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign blk_end    = (r_pos == AW'(NN - 1));

    // sample write into the bank memory
    assign o_smp_we   = accept;
    assign o_smp_bank = r_bank;
    assign o_smp_addr = r_pos;
    assign o_smp_data = i_sample;

    // block complete: hand the bank to the back end
    assign o_push       = accept && blk_end;
    assign o_job.bank   = r_bank;
    assign o_job.qshift = r_qshift;

    always_comb begin
        n_pos  = r_pos;
        n_bank = r_bank;
        if (accept) begin
            if (blk_end) begin
                n_pos  = '0;
                n_bank = !r_bank;
            end else begin
                n_pos = r_pos + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_bank   <= 1'b0;
            r_qshift <= '0;
        end else begin
            r_pos  <= n_pos;
            r_bank <= n_bank;
            if (i_cfg_we) begin
                r_qshift <= i_cfg_wdata;
            end
        end
    end

endmodule

@@ rtl/dfq_queue.sv @@
// two-entry job queue between front and back end
module dfq_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfq_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output dfq_pkg::t_job o_job
);
    import dfq_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop) r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/dfq_back.sv @@
// back end: row pass, column pass and quantization on one shared mac
module dfq_back #(
    parameter int BLOCK_N        = dfq_pkg::BLOCK_N_DEF,
    parameter int COEF_FRAC_BITS = dfq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_smp_we,
    input  logic                               i_smp_bank,
    input  logic [$clog2(BLOCK_N*BLOCK_N)-1:0] i_smp_addr,
    input  logic [dfq_pkg::SAMPLE_W-1:0]       i_smp_data,
    input  logic                               i_job_valid,
    input  dfq_pkg::t_job                      i_job,
    input  logic                               i_out_stall,
    output logic                               o_job_pop,
    output logic                               o_out_valid,
    output logic signed [dfq_pkg::LEVEL_W-1:0] o_level,
    output logic                               o_last
);
    import dfq_pkg::*;

    localparam int NN = BLOCK_N * BLOCK_N;
    localparam int AW = $clog2(NN);
    localparam int KW = $clog2(BLOCK_N);
    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 2;
    localparam int TW = F + 12;
    localparam int YW = 2 * F + 16;
    localparam int PW = TW + CW;
    localparam int SW = 7;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ROW   = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;
    localparam logic [1:0] PH_COL   = 2'd3;

    localparam logic [1:0] RG_UPPER = 2'd0;
    localparam logic [1:0] RG_DIAG  = 2'd1;
    localparam logic [1:0] RG_LOWER = 2'd2;

    // cosine rom
    logic signed [CW-1:0] cos_rom [NN];
    for (genvar gi = 0; gi < BLOCK_N; gi++) begin : g_row
        for (genvar gj = 0; gj < BLOCK_N; gj++) begin : g_col
            assign cos_rom[gi*BLOCK_N+gj] = CW'(cos_coef(BLOCK_N, F, gi, gj));
        end
    end

    // sample banks and row-pass store
    logic [SAMPLE_W-1:0] smem [2][NN];
    logic signed [TW-1:0] tmem [NN];

    logic [1:0]    r_phase, n_phase;
    logic [KW-1:0] r_r, r_c, r_k;
    t_job          r_job;
    logic          r_col_busy;
    logic          iss;
    logic          iss_col;
    logic          k_end, c_end, r_end;
    logic [AW-1:0] saddr, taddr, cidx, dest;
    logic [KW:0]   rc_sum;
    logic [1:0]    region;

    // stage 1: memory and rom read
    logic                 r_s1_v, r_s1_col, r_s1_first, r_s1_lastk, r_s1_lastel;
    logic [AW-1:0]        r_s1_dest;
    logic [1:0]           r_s1_region;
    logic [SAMPLE_W-1:0]  r_smp;
    logic signed [TW-1:0] r_trd;
    logic signed [CW-1:0] r_cos;
    logic signed [TW-1:0] mop;

    // stage 2: product
    logic                 r_s2_v, r_s2_col, r_s2_first, r_s2_lastk, r_s2_lastel;
    logic [AW-1:0]        r_s2_dest;
    logic [1:0]           r_s2_region;
    logic signed [PW-1:0] r_prod;

    // stage 3: accumulate
    logic signed [YW-1:0] r_acc;
    logic signed [YW-1:0] sum;

    // coefficient waiting for quantization
    logic                 r_y_v;
    logic signed [YW-1:0] r_y;
    logic [1:0]           r_y_region;
    logic                 r_y_last;
    logic                 out_load;

    // quantizer
    logic [SW-1:0]        sh;
    logic [YW-1:0]        mag;
    logic [YW-1:0]        shr;
    logic [YW-1:0]        q;
    logic [YW-1:0]        qr;
    logic                 sticky;
    logic                 inc;
    logic signed [LEVEL_W-1:0] lvl;

    assign k_end = (r_k == KW'(BLOCK_N - 1));
    assign c_end = (r_c == KW'(BLOCK_N - 1));
    assign r_end = (r_r == KW'(BLOCK_N - 1));

    // issue control
    always_comb begin
        case (r_phase)
            PH_ROW:  iss = 1'b1;
            PH_COL:  iss = !((r_k == '0) && r_col_busy);
            default: iss = 1'b0;
        endcase
    end
    assign iss_col = (r_phase == PH_COL);

    // operand addresses
    assign saddr = AW'(r_r * BLOCK_N + r_k);
    assign taddr = AW'(r_k * BLOCK_N + r_c);
    assign cidx  = iss_col ? AW'(r_r * BLOCK_N + r_k) : AW'(r_c * BLOCK_N + r_k);
    assign dest  = AW'(r_r * BLOCK_N + r_c);

    // quantizer region from the anti-diagonal
    assign rc_sum = {1'b0, r_r} + {1'b0, r_c};
    always_comb begin
        if (rc_sum < (KW + 1)'(BLOCK_N - 1)) region = RG_UPPER;
        else if (rc_sum == (KW + 1)'(BLOCK_N - 1)) region = RG_DIAG;
        else region = RG_LOWER;
    end

    assign o_job_pop = (r_phase == PH_DRAIN) && !r_s1_v && !r_s2_v;

    // sequencer, a new job waits until the last level of the previous one is loaded into the output register
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE:  if (i_job_valid && !r_col_busy) n_phase = PH_ROW;
            PH_ROW:   if (k_end && c_end && r_end) n_phase = PH_DRAIN;
            PH_DRAIN: if (o_job_pop) n_phase = PH_COL;
            PH_COL:   if (iss && k_end && c_end && r_end) n_phase = PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_r        <= '0;
            r_c        <= '0;
            r_k        <= '0;
            r_col_busy <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == PH_IDLE || o_job_pop) begin
                r_r <= '0;
                r_c <= '0;
                r_k <= '0;
            end else if (iss) begin
                if (!k_end) begin
                    r_k <= r_k + KW'(1);
                end else begin
                    r_k <= '0;
                    if (!c_end) begin
                        r_c <= r_c + KW'(1);
                    end else begin
                        r_c <= '0;
                        r_r <= r_end ? '0 : r_r + KW'(1);
                    end
                end
            end
            if (iss && iss_col && (r_k == '0)) r_col_busy <= 1'b1;
            else if (out_load) r_col_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_job_valid && !r_col_busy) begin
            r_job <= i_job;
        end
    end

    // sample bank writes
    always_ff @(posedge i_clk) begin
        if (i_smp_we) begin
            smem[i_smp_bank][i_smp_addr] <= i_smp_data;
        end
    end

    // stage 1 reads
    always_ff @(posedge i_clk) begin
        r_smp       <= smem[r_job.bank][saddr];
        r_trd       <= tmem[taddr];
        r_cos       <= cos_rom[cidx];
        r_s1_col    <= iss_col;
        r_s1_first  <= (r_k == '0);
        r_s1_lastk  <= k_end;
        r_s1_lastel <= k_end && c_end && r_end;
        r_s1_dest   <= dest;
        r_s1_region <= region;
    end

    // stage 2 multiply
    assign mop = r_s1_col ? r_trd : $signed({{(TW - SAMPLE_W){1'b0}}, r_smp});

    always_ff @(posedge i_clk) begin
        r_prod      <= mop * r_cos;
        r_s2_col    <= r_s1_col;
        r_s2_first  <= r_s1_first;
        r_s2_lastk  <= r_s1_lastk;
        r_s2_lastel <= r_s1_lastel;
        r_s2_dest   <= r_s1_dest;
        r_s2_region <= r_s1_region;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= iss;
            r_s2_v <= r_s1_v;
        end
    end

    // stage 3 accumulate, row results to the store, column results onward
    assign sum = (r_s2_first ? YW'(0) : r_acc) + YW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc <= sum;
            if (r_s2_lastk && !r_s2_col) begin
                tmem[r_s2_dest] <= TW'(sum);
            end
            if (r_s2_lastk && r_s2_col) begin
                r_y        <= sum;
                r_y_region <= r_s2_region;
                r_y_last   <= r_s2_lastel;
            end
        end
    end

    assign out_load = r_y_v && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (r_s2_v && r_s2_lastk && r_s2_col) begin
            r_y_v <= 1'b1;
        end else if (out_load) begin
            r_y_v <= 1'b0;
        end
    end

    // round to nearest, ties to even, then saturate
    assign sh     = SW'(2 * F) + SW'(r_job.qshift) + SW'(r_y_region) - SW'(1);
    assign mag    = r_y[YW-1] ? YW'(-r_y) : YW'(r_y);
    assign shr    = mag >> sh;
    assign q      = shr >> 1;
    assign sticky = ((mag & ~({YW{1'b1}} << sh)) != '0);
    assign inc    = shr[0] && (sticky || q[0]);
    assign qr     = q + YW'(inc);

    always_comb begin
        if (r_y[YW-1]) begin
            if (qr > YW'(-LEVEL_MIN)) lvl = LEVEL_W'(LEVEL_MIN);
            else lvl = LEVEL_W'(-qr);
        end else begin
            if (qr > YW'(LEVEL_MAX)) lvl = LEVEL_W'(LEVEL_MAX);
            else lvl = LEVEL_W'(qr);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_level <= lvl;
            o_last  <= r_y_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/dfq_checker.sv @@
// port-level checker for the dct quantizer and its bind
`include "dct2d_forward_quantizer_assert.svh"

module dfq_checker #(
    parameter int BLOCK_N = dfq_pkg::BLOCK_N_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [dfq_pkg::LEVEL_W-1:0] o_level,
    input logic                               o_last
);
    import dfq_pkg::*;

    localparam int NN = BLOCK_N * BLOCK_N;
    localparam int AW = $clog2(NN);

    logic [AW-1:0] r_in_cnt;
    logic [AW-1:0] r_out_cnt;
    logic [1:0]    r_pend;
    logic          in_acc;
    logic          out_acc;
    logic          blk_in;
    logic          blk_out;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = o_out_valid && !i_out_stall;
    assign blk_in    = in_acc && (r_in_cnt == AW'(NN - 1));
    assign blk_out   = out_acc && o_last;

    // request counters and blocks loaded but not fully delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_pend    <= '0;
        end else begin
            if (in_acc) r_in_cnt <= blk_in ? '0 : r_in_cnt + AW'(1);
            if (out_acc) r_out_cnt <= (r_out_cnt == AW'(NN - 1)) ? '0 : r_out_cnt + AW'(1);
            case ({blk_in, blk_out})
                2'b10:   r_pend <= r_pend + 2'd1;
                2'b01:   r_pend <= r_pend - 2'd1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    `DFQ_ASSERT_IMPL(a_last_pos, o_out_valid, o_last == (r_out_cnt == AW'(NN - 1)), "last flag misplaced")
    `DFQ_ASSERT_IMPL(a_out_pend, o_out_valid, r_pend != 2'd0, "level without a loaded block")
    `DFQ_ASSERT_IMPL(a_stall_pend, o_in_stall, r_pend >= 2'd2, "input stalled with a free bank")
    `DFQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_level) && $stable(o_last), "stalled level changed")

endmodule

bind dct2d_forward_quantizer dfq_checker #(.BLOCK_N(BLOCK_N)) u_dfq_checker (.*);

@@ tb/dct2d_forward_quantizer_test.sv @@
// self-checking testbench for the forward dct quantizer with its own transform predictor
module dct2d_forward_quantizer_test;
    import dfq_pkg::*;

    localparam int N        = BLOCK_N_DEF;
    localparam int AREA     = N * N;
    localparam int FRAC     = COEF_FRAC_BITS_DEF;
    localparam int MAX_WAIT = 13;
    localparam int WD_LIMIT = 12000;
    localparam int SETTLE   = 60;
    localparam longint unsigned PI_FIX  = 64'd3373259426;
    localparam longint unsigned ONE_FIX = 64'd1073741824;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [SAMPLE_W-1:0]        i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [LEVEL_W-1:0]  o_level;
    logic                       o_last;
    logic                       i_cfg_we;
    logic [QSHIFT_W-1:0]        i_cfg_wdata;

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      last;
    } t_level;

    // predictor state
    longint                basis [AREA];
    logic [SAMPLE_W-1:0]   pixels [AREA];
    int                    fill_pos;
    logic [QSHIFT_W-1:0]   shift_reg;
    t_level                pending_levels [$];

    int  fail_count;
    int  report_count;
    int  idle_cycles;
    int  hold_off;
    bit  no_gaps;

    dct2d_forward_quantizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // integer square root
    function automatic longint unsigned root_u64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // cos(pi*m/(2n)) in q30 by a truncated series
    function automatic longint unsigned cosine_fix(input int m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (PI_FIX * longint'(m)) / longint'(2 * N);
        x2   = (x * x) >> 30;
        term = ONE_FIX;
        acc  = longint'(ONE_FIX);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ONE_FIX)) acc = longint'(ONE_FIX);
        return longint'(acc);
    endfunction

    // orthonormal basis table in fixed point
    task automatic build_basis();
        longint unsigned s0;
        longint unsigned s1;
        longint unsigned mag;
        int              m;
        int              sh;
        bit              neg;
        s0 = root_u64((64'd1 << 60) / N);
        s1 = root_u64((64'd1 << 61) / N);
        sh = 60 - FRAC;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                m   = ((2 * j + 1) * i) % (4 * N);
                neg = 1'b0;
                if (m > 2 * N) m = 4 * N - m;
                if (m > N) begin
                    m   = 2 * N - m;
                    neg = 1'b1;
                end
                if (i == 0) mag = s0 * ONE_FIX;
                else mag = s1 * cosine_fix(m);
                mag = (mag + (64'd1 << (sh - 1))) >> sh;
                basis[i * N + j] = neg ? -longint'(mag) : longint'(mag);
            end
        end
    endtask

    // power of two step, round half to even, clamp to level range
    function automatic logic signed [LEVEL_W-1:0] quantize_coef(input longint y, input int s);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        longint          r;
        neg  = y < 0;
        mag  = neg ? longint'(-y) : longint'(y);
        q    = mag >> s;
        rem  = mag & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q++;
        if (q > 4096) q = 4096;
        r = neg ? -longint'(q) : longint'(q);
        if (r > LEVEL_MAX) r = LEVEL_MAX;
        if (r < LEVEL_MIN) r = LEVEL_MIN;
        return r[LEVEL_W-1:0];
    endfunction

    // row pass, column pass and quantization of a full block
    task automatic transform_block();
        longint rows [AREA];
        longint acc;
        int     region;
        t_level lv;
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++) begin
                acc = 0;
                for (int k = 0; k < N; k++)
                    acc += longint'(pixels[r * N + k]) * basis[c * N + k];
                rows[r * N + c] = acc;
            end
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++) begin
                acc = 0;
                for (int k = 0; k < N; k++)
                    acc += basis[r * N + k] * rows[k * N + c];
                region   = (r + c < N - 1) ? 0 : ((r + c == N - 1) ? 1 : 2);
                lv.level = quantize_coef(acc, 2 * FRAC + int'(shift_reg) + region);
                lv.last  = (r * N + c == AREA - 1);
                pending_levels.insert(pending_levels.size(), lv);
            end
    endtask

    // one request into the block, valid kept high for a back-to-back follower
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample   = s;
        do @(posedge i_clk); while (o_in_stall);
        pixels[fill_pos] = s;
        fill_pos++;
        if (fill_pos == AREA) begin
            fill_pos = 0;
            transform_block();
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // wait until every predicted level has come out, then let the block settle
    task automatic drain();
        release_input();
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [QSHIFT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        shift_reg   = v;
    endtask

    task automatic send_random_block(input int span);
        for (int i = 0; i < AREA; i++)
            send_sample(SAMPLE_W'($urandom_range(0, span)));
    endtask

    // flat blocks at both ends of the sample range
    task automatic test_flat_extremes();
        write_shift(4'd0);
        for (int i = 0; i < AREA; i++) send_sample(8'hff);
        for (int i = 0; i < AREA; i++) send_sample(8'h00);
        drain();
    endtask

    // checkerboard drives the highest frequencies and every sample bit
    task automatic test_checkerboard();
        write_shift(4'd1);
        for (int i = 0; i < AREA; i++)
            send_sample(((i / N + i % N) % 2) ? 8'haa : 8'h55);
        drain();
    endtask

    // random content at the largest step
    task automatic test_random_steps();
        write_shift(4'd15);
        send_random_block(255);
        drain();
    endtask

    // the level side holds off long enough that the block stalls its input
    task automatic test_backpressure();
        write_shift(4'($urandom_range(0, 15)));
        hold_off = 3000;
        no_gaps  = 1'b1;
        send_random_block(255);
        send_random_block(15);
        send_random_block(255);
        no_gaps  = 1'b0;
        drain();
    endtask

    // level receiver and checker
    always begin
        int gap;
        @(negedge i_clk);
        if (hold_off > 0) begin
            i_out_stall = 1'b1;
            repeat (hold_off) @(negedge i_clk);
            hold_off = 0;
        end
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_out_stall = 1'b1;
            repeat (gap) @(negedge i_clk);
        end
        i_out_stall = 1'b0;
        do @(posedge i_clk); while (!o_out_valid);
        if (pending_levels.size() == 0) begin
            fail_count++;
            if (report_count < 10) begin
                report_count++;
                $display("unexpected level %0d last %0b", o_level, o_last);
            end
        end else begin
            t_level want;
            want = pending_levels.pop_front();
            if (o_level !== want.level || o_last !== want.last) begin
                fail_count++;
                if (report_count < 10) begin
                    report_count++;
                    $display("level mismatch: expected %0d last %0b, got %0d last %0b",
                             want.level, want.last, o_level, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_out_stall  = 1'b1;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        fill_pos     = 0;
        shift_reg    = '0;
        fail_count   = 0;
        report_count = 0;
        idle_cycles  = 0;
        hold_off     = 0;
        no_gaps      = 1'b0;
        build_basis();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_flat_extremes();
        test_checkerboard();
        test_random_steps();
        test_backpressure();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dfq_pkg.sv
rtl/dfq_front.sv
rtl/dfq_queue.sv
rtl/dfq_back.sv
rtl/dct2d_forward_quantizer.sv
rtl/dfq_checker.sv
tb/dct2d_forward_quantizer_test.sv
